// ===== sv/dfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Datagram deframer package
// Shared constants, status codes, result and queue-push types, and the
// byte-wide reflected CRC-32 step.
// ----------------------------------------------------------------------------
package dfc_pkg;

  // Header layout: byte offsets of each little-endian field.
  localparam int PosW = 5;
  localparam logic [PosW-1:0] HeaderBytes = 5'd26;
  localparam logic [PosW-1:0] OffVersion  = 5'd4;
  localparam logic [PosW-1:0] OffType     = 5'd6;
  localparam logic [PosW-1:0] OffPriority = 5'd8;
  localparam logic [PosW-1:0] OffSequence = 5'd10;
  localparam logic [PosW-1:0] OffStamp    = 5'd14;
  localparam logic [PosW-1:0] OffLength   = 5'd18;
  localparam logic [PosW-1:0] OffCrc      = 5'd22;

  localparam logic [31:0] MagicValue = 32'h55AA55AA;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;

  localparam logic [15:0] VersionReset = 16'd1;

  // Default depth of the queue between front and back.
  localparam int QueueDepthDefault = 4;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusTooShort    = 3'd1,
    StatusBadMagic    = 3'd2,
    StatusTruncated   = 3'd3,
    StatusCrcMismatch = 3'd4
  } dfc_status_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    dfc_status_t frame_status;
    logic        version_too_new;
    logic [15:0] msg_version;
    logic [15:0] msg_type;
    logic [15:0] msg_priority;
    logic [31:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] payload_length;
    logic        last_of_run;
  } dfc_result_t;

  // Up to two results leave the front for one accepted beat.
  typedef struct packed {
    logic [1:0]  count;
    dfc_result_t first;
    dfc_result_t second;
  } dfc_push_t;

  // One byte through the reflected CRC-32, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

// ===== sv/dfc_byte_if.sv =====
// ----------------------------------------------------------------------------
// Datagram byte channel
// Carries one datagram byte per beat with its end marker.
// ----------------------------------------------------------------------------
interface dfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

// ===== sv/dfc_result_if.sv =====
// ----------------------------------------------------------------------------
// Deframer result channel
// Carries one payload byte or one end-of-datagram status per beat.
// ----------------------------------------------------------------------------
interface dfc_result_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_status;
  logic        version_too_new;
  logic [15:0] msg_version;
  logic [15:0] msg_type;
  logic [15:0] msg_priority;
  logic [31:0] sequence_number;
  logic [31:0] time_stamp;
  logic [31:0] payload_length;
  logic        last_of_run;

  modport source (output valid, output is_status, output payload_byte, output frame_status,
                  output version_too_new, output msg_version, output msg_type,
                  output msg_priority, output sequence_number, output time_stamp,
                  output payload_length, output last_of_run, input ready);
  modport sink   (input valid, input is_status, input payload_byte, input frame_status,
                  input version_too_new, input msg_version, input msg_type,
                  input msg_priority, input sequence_number, input time_stamp,
                  input payload_length, input last_of_run, output ready);
endinterface

// ===== sv/dfc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Deframer configuration channel
// Write channel for the supported protocol version register.
// ----------------------------------------------------------------------------
interface dfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] supported_version;

  modport source (output valid, output supported_version, input ready);
  modport sink   (input valid, input supported_version, output ready);
endinterface

// ===== sv/dfc_front.sv =====
// ----------------------------------------------------------------------------
// Deframer front end
// Accepts bytes, captures the header, runs the CRC over the declared payload
// and classifies each beat into payload and status results for the queue.
// ----------------------------------------------------------------------------
module dfc_front (
  input  logic              clk,
  input  logic              rst,
  dfc_cfg_if.sink           cfg,
  dfc_byte_if.sink          bytes,
  input  logic              room,
  output dfc_pkg::dfc_push_t push
);
  import dfc_pkg::*;

  logic [15:0]     supported_version;
  logic [PosW-1:0] hdr_pos;
  logic [31:0]     magic_word;
  logic [15:0]     version_word;
  logic [15:0]     type_word;
  logic [15:0]     priority_word;
  logic [31:0]     sequence_word;
  logic [31:0]     stamp_word;
  logic [31:0]     length_word;
  logic [31:0]     expected_crc;
  logic [31:0]     running_crc;
  logic [31:0]     remaining;

  logic [PosW-1:0] hdr_pos_next;
  logic [31:0]     magic_next;
  logic [15:0]     version_next;
  logic [15:0]     type_next;
  logic [15:0]     priority_next;
  logic [31:0]     sequence_next;
  logic [31:0]     stamp_next;
  logic [31:0]     length_next;
  logic [31:0]     expected_next;
  logic [31:0]     running_crc_next;
  logic [31:0]     remaining_next;

  logic        accept;
  logic        in_header;
  logic        is_payload;
  logic        too_new;
  dfc_status_t status_code;
  dfc_result_t payload_entry;
  dfc_result_t status_entry;

  assign cfg.ready   = 1'b1;
  assign bytes.ready = room;
  assign accept      = bytes.valid && room;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      supported_version <= VersionReset;
    end else if (cfg.valid && cfg.ready) begin
      supported_version <= cfg.supported_version;
    end
  end

  assign in_header = hdr_pos < HeaderBytes;

  // Header capture: drop the byte into its field lane.
  always_comb begin
    logic [PosW-1:0] off;
    magic_next    = magic_word;
    version_next  = version_word;
    type_next     = type_word;
    priority_next = priority_word;
    sequence_next = sequence_word;
    stamp_next    = stamp_word;
    length_next   = length_word;
    expected_next = expected_crc;
    off           = '0;
    if (in_header) begin
      if (hdr_pos < OffVersion) begin
        magic_next[{hdr_pos[1:0], 3'b000} +: 8] = bytes.data_byte;
      end else if (hdr_pos < OffType) begin
        off = hdr_pos - OffVersion;
        version_next[{off[0], 3'b000} +: 8] = bytes.data_byte;
      end else if (hdr_pos < OffPriority) begin
        off = hdr_pos - OffType;
        type_next[{off[0], 3'b000} +: 8] = bytes.data_byte;
      end else if (hdr_pos < OffSequence) begin
        off = hdr_pos - OffPriority;
        priority_next[{off[0], 3'b000} +: 8] = bytes.data_byte;
      end else if (hdr_pos < OffStamp) begin
        off = hdr_pos - OffSequence;
        sequence_next[{off[1:0], 3'b000} +: 8] = bytes.data_byte;
      end else if (hdr_pos < OffLength) begin
        off = hdr_pos - OffStamp;
        stamp_next[{off[1:0], 3'b000} +: 8] = bytes.data_byte;
      end else if (hdr_pos < OffCrc) begin
        off = hdr_pos - OffLength;
        length_next[{off[1:0], 3'b000} +: 8] = bytes.data_byte;
      end else begin
        off = hdr_pos - OffCrc;
        expected_next[{off[1:0], 3'b000} +: 8] = bytes.data_byte;
      end
    end
  end

  // Payload tracking: the remaining count is loaded with the last header byte.
  assign hdr_pos_next = in_header ? hdr_pos + 1'b1 : hdr_pos;
  assign is_payload   = !in_header && (magic_word == MagicValue) && (remaining != '0);
  assign running_crc_next = is_payload ? crc_byte(running_crc, bytes.data_byte)
                                       : running_crc;

  always_comb begin
    if (hdr_pos == HeaderBytes - 1'b1) begin
      remaining_next = length_next;
    end else if (is_payload) begin
      remaining_next = remaining - 1'b1;
    end else begin
      remaining_next = remaining;
    end
  end

  // End-of-datagram classification.
  assign too_new = version_next > supported_version;

  always_comb begin
    if (hdr_pos_next < HeaderBytes) begin
      status_code = StatusTooShort;
    end else if (magic_next != MagicValue) begin
      status_code = StatusBadMagic;
    end else if (remaining_next != '0) begin
      status_code = StatusTruncated;
    end else if ((running_crc_next ^ CrcInit) != expected_next) begin
      status_code = StatusCrcMismatch;
    end else begin
      status_code = StatusOk;
    end
  end

  // Result entries for this beat.
  always_comb begin
    payload_entry.is_status       = 1'b0;
    payload_entry.payload_byte    = bytes.data_byte;
    payload_entry.frame_status    = StatusOk;
    payload_entry.version_too_new = 1'b0;
    payload_entry.msg_version     = version_next;
    payload_entry.msg_type        = type_next;
    payload_entry.msg_priority    = priority_next;
    payload_entry.sequence_number = sequence_next;
    payload_entry.time_stamp      = stamp_next;
    payload_entry.payload_length  = length_next;
    payload_entry.last_of_run     = !bytes.end_of_datagram;

    status_entry                 = payload_entry;
    status_entry.is_status       = 1'b1;
    status_entry.payload_byte    = 8'd0;
    status_entry.frame_status    = status_code;
    status_entry.version_too_new = too_new && (status_code != StatusTooShort)
                                   && (status_code != StatusBadMagic);
    status_entry.last_of_run     = 1'b1;
  end

  always_comb begin
    push.count  = accept ? (2'(is_payload) + 2'(bytes.end_of_datagram)) : 2'd0;
    push.first  = is_payload ? payload_entry : status_entry;
    push.second = status_entry;
  end

  // Frame state: cleared after the final beat of a datagram.
  always_ff @(posedge clk) begin
    if (rst || (accept && bytes.end_of_datagram)) begin
      hdr_pos       <= '0;
      magic_word    <= '0;
      version_word  <= '0;
      type_word     <= '0;
      priority_word <= '0;
      sequence_word <= '0;
      stamp_word    <= '0;
      length_word   <= '0;
      expected_crc  <= '0;
      running_crc   <= CrcInit;
      remaining     <= '0;
    end else if (accept) begin
      hdr_pos       <= hdr_pos_next;
      magic_word    <= magic_next;
      version_word  <= version_next;
      type_word     <= type_next;
      priority_word <= priority_next;
      sequence_word <= sequence_next;
      stamp_word    <= stamp_next;
      length_word   <= length_next;
      expected_crc  <= expected_next;
      running_crc   <= running_crc_next;
      remaining     <= remaining_next;
    end
  end

  // A final beat always leaves the next datagram starting at header byte zero.
  assert property (@(posedge clk) disable iff (rst)
    (accept && bytes.end_of_datagram) |=> (hdr_pos == '0))
    else $error("frame state not cleared after end of datagram");

  // Payload bytes are only counted down once the header is complete.
  assert property (@(posedge clk) disable iff (rst)
    (hdr_pos < HeaderBytes) |-> (remaining == '0))
    else $error("payload count live during header");

  // A double push is a payload byte followed by its status.
  assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (!push.first.is_status && push.second.is_status))
    else $error("double push out of order");

endmodule

// ===== sv/dfc_queue.sv =====
// ----------------------------------------------------------------------------
// Deframer result queue
// Small queue between front and back; takes up to two entries per cycle and
// hands out one.
// ----------------------------------------------------------------------------
module dfc_queue #(
  parameter int Depth = dfc_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  dfc_pkg::dfc_push_t  push,
  input  logic                pop,
  output logic                room,
  output logic                head_valid,
  output dfc_pkg::dfc_result_t head
);
  import dfc_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  dfc_result_t     mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr_second;
  logic [CntW-1:0] count_next;

  function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_second = step_ptr(wr_ptr);
  assign room          = count <= CntW'(Depth - 2);
  assign head_valid    = count != '0;
  assign head          = mem[rd_ptr];
  assign count_next    = count + CntW'(push.count) - CntW'(pop);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_second] <= push.second;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.count == 2'd1) begin
        wr_ptr <= wr_ptr_second;
      end else if (push.count == 2'd2) begin
        wr_ptr <= step_ptr(wr_ptr_second);
      end
      if (pop) begin
        rd_ptr <= step_ptr(rd_ptr);
      end
      count <= count_next;
    end
  end

  // The front never pushes more than the free space.
  assert property (@(posedge clk) disable iff (rst)
    (int'(count) + int'(push.count)) <= Depth)
    else $error("result queue overflow");

  // The back only takes an entry that is there.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("result queue underflow");

  // Fill level tracks pushes and pops.
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count_next)))
    else $error("result queue fill level drift");

endmodule

// ===== sv/dfc_back.sv =====
// ----------------------------------------------------------------------------
// Deframer back end
// Output register that drains the queue one result beat per cycle while ready is high.
// ----------------------------------------------------------------------------
module dfc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  dfc_pkg::dfc_result_t head,
  output logic                 pop,
  dfc_result_if.source         results
);
  import dfc_pkg::*;

  logic        out_valid;
  dfc_result_t out_data;
  logic        load_ok;

  assign load_ok = !out_valid || results.ready;
  assign pop     = head_valid && load_ok;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= head;
    end
  end

  assign results.valid           = out_valid;
  assign results.is_status       = out_data.is_status;
  assign results.payload_byte    = out_data.payload_byte;
  assign results.frame_status    = out_data.frame_status;
  assign results.version_too_new = out_data.version_too_new;
  assign results.msg_version     = out_data.msg_version;
  assign results.msg_type        = out_data.msg_type;
  assign results.msg_priority    = out_data.msg_priority;
  assign results.sequence_number = out_data.sequence_number;
  assign results.time_stamp      = out_data.time_stamp;
  assign results.payload_length  = out_data.payload_length;
  assign results.last_of_run     = out_data.last_of_run;

  // A status beat always closes its run.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_status) |-> out_data.last_of_run)
    else $error("status beat not marked last of run");

  // A waiting result is not replaced while stalled.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result lost");

  // Nothing is taken from the queue while a result waits.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !pop)
    else $error("queue popped during stall");

endmodule

// ===== sv/message_deframer_crc_check_core.sv =====
// ----------------------------------------------------------------------------
// Datagram deframer with CRC-32 check
// Top level: front end, result queue and output register.
// ----------------------------------------------------------------------------
// The block takes one datagram byte per beat on the bytes channel and accepts
// one byte every clock cycle while the result queue has room for two entries.
// It captures a 26-byte little-endian header, passes the declared number of
// payload bytes out as payload results when the magic word matches, and runs
// the reflected CRC-32 over them in the same cycle the byte is accepted. The
// byte marked end_of_datagram also yields a status result, after its payload
// result if it carries one. Results leave through a single output register at
// one per cycle while the result side takes them, so a final byte that is also a
// payload byte adds one extra result that the queue absorbs; the sustained input
// rate is one byte per cycle while the result side keeps taking beats. A result
// passes through the result queue and then the output register before it
// appears on the result port. The supported version register resets to 1 and
// should be written only while no datagram is in flight.
module message_deframer_crc_check_core #(
  parameter int QueueDepth = dfc_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  dfc_cfg_if.sink       cfg,
  dfc_byte_if.sink      bytes,
  dfc_result_if.source  results
);
  import dfc_pkg::*;

  dfc_push_t   push;
  logic        room;
  logic        head_valid;
  dfc_result_t head;
  logic        pop;

  dfc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .bytes (bytes),
    .room  (room),
    .push  (push)
  );

  dfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  dfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );

endmodule
